// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the line number decoder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== hdl/ildec_pkg.sv =====
// ---------------------------------------------------------------------------
// ildec_pkg
// Types and constants shared by the intercom line number decoder modules.
// ---------------------------------------------------------------------------
package ildec_pkg;

  localparam int RUN_WIDTH_DEF = 16;
  localparam int THR_W         = 16;
  localparam int CFG_ADDR_W    = 3;
  localparam int NUM_W         = 12;
  localparam int PULSE_W       = 8;
  localparam int MODE_W        = 3;

  // Call states.
  localparam logic [MODE_W-1:0] MODE_NOT_CONNECTED = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CONNECTED     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FIRST         = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SECOND        = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RECEIVED      = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ENDED         = 3'd5;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_DISCONNECT = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CALL_START = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DIGIT_END  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_IDLE_HIGH  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CALL_END   = 3'd4;

  // Threshold reset values.
  localparam logic [THR_W-1:0] THR_DISCONNECT_RST = 16'd1000;
  localparam logic [THR_W-1:0] THR_CALL_START_RST = 16'd100;
  localparam logic [THR_W-1:0] THR_DIGIT_END_RST  = 16'd50;
  localparam logic [THR_W-1:0] THR_IDLE_HIGH_RST  = 16'd500;
  localparam logic [THR_W-1:0] THR_CALL_END_RST   = 16'd300;

  localparam logic [PULSE_W-1:0] PULSE_ONE    = 8'd1;
  localparam logic [PULSE_W-1:0] PULSE_MAX    = 8'd255;
  localparam logic [PULSE_W-1:0] PULSE_ELEVEN = 8'd11;

  typedef struct packed {
    logic [THR_W-1:0] disconnect;
    logic [THR_W-1:0] call_start;
    logic [THR_W-1:0] digit_end;
    logic [THR_W-1:0] idle_high;
    logic [THR_W-1:0] call_end;
  } ildec_cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic               last_level;
    logic [PULSE_W-1:0] pulse_count;
    logic [NUM_W-1:0]   number_acc;
    logic               lamp;
    logic [NUM_W-1:0]   shown;
  } ildec_ctrl_t;

  localparam ildec_ctrl_t CTRL_RST = '{
    mode:        MODE_CONNECTED,
    last_level:  1'b0,
    pulse_count: PULSE_ONE,
    number_acc:  '0,
    lamp:        1'b1,
    shown:       '0
  };

endpackage

// ===== hdl/ildec_cfg.sv =====
// ---------------------------------------------------------------------------
// ildec_cfg
// Threshold register file written through the configuration channel.
// ---------------------------------------------------------------------------
module ildec_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ildec_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ildec_pkg::THR_W-1:0]    cfg_data,
  output ildec_pkg::ildec_cfg_t          thr_o
);
  import ildec_pkg::*;

  ildec_cfg_t thr_r;
  ildec_cfg_t thr_nxt;

  assign cfg_ready = 1'b1;
  assign thr_o     = thr_r;

  always_comb begin
    thr_nxt = thr_r;
    if (cfg_valid) begin
      case (cfg_addr)
        REG_DISCONNECT: thr_nxt.disconnect = cfg_data;
        REG_CALL_START: thr_nxt.call_start = cfg_data;
        REG_DIGIT_END:  thr_nxt.digit_end  = cfg_data;
        REG_IDLE_HIGH:  thr_nxt.idle_high  = cfg_data;
        REG_CALL_END:   thr_nxt.call_end   = cfg_data;
        default:        thr_nxt = thr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.disconnect <= THR_DISCONNECT_RST;
      thr_r.call_start <= THR_CALL_START_RST;
      thr_r.digit_end  <= THR_DIGIT_END_RST;
      thr_r.idle_high  <= THR_IDLE_HIGH_RST;
      thr_r.call_end   <= THR_CALL_END_RST;
    end else begin
      thr_r <= thr_nxt;
    end
  end

endmodule

// ===== hdl/ildec_step.sv =====
// ---------------------------------------------------------------------------
// ildec_step
// Next-state logic of the call state machine for one sampled line level.
// ---------------------------------------------------------------------------
module ildec_step #(
  parameter int RUN_WIDTH = ildec_pkg::RUN_WIDTH_DEF
) (
  input  logic                   level_i,
  input  ildec_pkg::ildec_cfg_t  thr_i,
  input  ildec_pkg::ildec_ctrl_t ctrl_i,
  input  logic [RUN_WIDTH-1:0]   low_run_i,
  input  logic [RUN_WIDTH-1:0]   high_run_i,
  output ildec_pkg::ildec_ctrl_t ctrl_o,
  output logic [RUN_WIDTH-1:0]   low_run_o,
  output logic [RUN_WIDTH-1:0]   high_run_o,
  output logic                   number_valid_o
);
  import ildec_pkg::*;

  localparam int CMP_W = (RUN_WIDTH > THR_W) ? RUN_WIDTH : THR_W;
  localparam logic [RUN_WIDTH-1:0] RUN_MAX = '1;
  localparam logic [RUN_WIDTH-1:0] RUN_ONE = {{(RUN_WIDTH-1){1'b0}}, 1'b1};
  localparam logic [NUM_W:0] NUM_ONE     = 13'd1;
  localparam logic [NUM_W:0] NUM_HUNDRED = 13'd100;
  localparam logic [NUM_W:0] NUM_HI_LIM  = 13'd110;

  function automatic logic [RUN_WIDTH-1:0] run_inc(logic [RUN_WIDTH-1:0] v);
    return (v == RUN_MAX) ? v : v + RUN_ONE;
  endfunction

  function automatic logic run_ge(logic [RUN_WIDTH-1:0] run, logic [THR_W-1:0] thr);
    return CMP_W'(run) >= CMP_W'(thr);
  endfunction

  // Mode change: lamp follows the new mode, edge and pulse tracking restart.
  function automatic ildec_ctrl_t enter_mode(ildec_ctrl_t c, logic [MODE_W-1:0] m);
    ildec_ctrl_t r;
    r = c;
    r.mode = m;
    if (m == MODE_NOT_CONNECTED) r.lamp = 1'b0;
    if (m == MODE_CONNECTED)     r.lamp = 1'b1;
    r.last_level  = 1'b0;
    r.pulse_count = PULSE_ONE;
    return r;
  endfunction

  ildec_ctrl_t          c;
  logic [RUN_WIDTH-1:0] lr;
  logic [RUN_WIDTH-1:0] hr;
  logic                 done;
  logic [NUM_W-1:0]     tens;
  logic [PULSE_W-1:0]   units;
  logic [NUM_W:0]       num;

  always_comb begin
    c     = ctrl_i;
    lr    = low_run_i;
    hr    = high_run_i;
    done  = 1'b0;
    tens  = '0;
    units = '0;
    num   = '0;
    case (ctrl_i.mode)
      MODE_NOT_CONNECTED: begin
        if (level_i) begin
          c  = enter_mode(c, MODE_CONNECTED);
          lr = '0;
          hr = '0;
        end
      end
      MODE_CONNECTED: begin
        if (!level_i) begin
          lr = run_inc(lr);
          if (run_ge(lr, thr_i.disconnect)) begin
            c  = enter_mode(c, MODE_NOT_CONNECTED);
            lr = '0;
            hr = '0;
          end
        end else if (run_ge(lr, thr_i.call_start)) begin
          c  = enter_mode(c, MODE_FIRST);
          lr = '0;
          hr = '0;
        end
      end
      MODE_FIRST, MODE_SECOND: begin
        // A falling edge counts one dial pulse.
        if (c.last_level && !level_i && (c.pulse_count != PULSE_MAX))
          c.pulse_count = c.pulse_count + PULSE_ONE;
        c.last_level = level_i;
        if (!level_i) begin
          hr = '0;
          lr = run_inc(lr);
        end else begin
          lr = '0;
          hr = run_inc(hr);
          if (run_ge(hr, thr_i.digit_end)) begin
            if (ctrl_i.mode == MODE_FIRST) begin
              // Multiply by ten as two shifted copies.
              tens = {1'b0, c.pulse_count, 3'b000} + {3'b000, c.pulse_count, 1'b0};
              c.number_acc = tens;
              c  = enter_mode(c, MODE_SECOND);
            end else begin
              // Eleven pulses stand for the digit one.
              units = (c.pulse_count == PULSE_ELEVEN) ? PULSE_ONE : c.pulse_count;
              num = {1'b0, c.number_acc} + {5'b00000, units} - NUM_ONE;
              if ((num > NUM_HUNDRED) && (num < NUM_HI_LIM))
                num = num - NUM_HUNDRED;
              c.number_acc = num[NUM_W-1:0];
              c.shown      = num[NUM_W-1:0];
              done = 1'b1;
              c  = enter_mode(c, MODE_RECEIVED);
            end
            lr = '0;
            hr = '0;
          end
          // Sees the cleared high run after a digit has ended.
          if (run_ge(hr, thr_i.idle_high)) begin
            c  = enter_mode(c, MODE_CONNECTED);
            lr = '0;
            hr = '0;
          end
        end
      end
      MODE_RECEIVED, MODE_ENDED: begin
        if (!level_i) begin
          lr = run_inc(lr);
          if (ctrl_i.mode == MODE_RECEIVED) begin
            if (run_ge(lr, thr_i.call_end)) begin
              c  = enter_mode(c, MODE_ENDED);
              lr = '0;
              hr = '0;
            end
          end else if (run_ge(lr, thr_i.disconnect)) begin
            c  = enter_mode(c, MODE_NOT_CONNECTED);
            lr = '0;
            hr = '0;
          end
        end else begin
          hr = run_inc(hr);
          if (run_ge(hr, thr_i.idle_high)) begin
            c  = enter_mode(c, MODE_CONNECTED);
            lr = '0;
            hr = '0;
          end
        end
      end
      default: begin
        c  = enter_mode(c, MODE_CONNECTED);
        lr = '0;
        hr = '0;
      end
    endcase
  end

  assign ctrl_o         = c;
  assign low_run_o      = lr;
  assign high_run_o     = hr;
  assign number_valid_o = done;

endmodule

// ===== hdl/intercom_line_number_decoder_core.sv =====
// ---------------------------------------------------------------------------
// Intercom line number decoder core
// Decodes the flat number dialled on an intercom line from one sampled line
// level per item and reports the call state after every item.
// ---------------------------------------------------------------------------
//
// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+-----------------------------
// in_      | slave     | in_tvalid / in_tready | line level in tdata bit 0
// out_     | master    | out_tvalid/out_tready | state, lamp, number; tuser flag
// cfg_     | slave     | cfg_valid / cfg_ready | threshold index and value
//
// Every input item yields exactly one result item. An accepted item sits in
// the input register and its result is loaded into the output register once
// that register is free or being emptied, and the block sustains one item
// per cycle while the output is not stalled; the call state machine update is
// the only path between the two registers. A stalled output holds its item
// and the input register, and the input stalls only when both are full.
// Reset is synchronous and active low; the configuration port is always ready.
// ---------------------------------------------------------------------------
module intercom_line_number_decoder_core #(
  parameter int RUN_WIDTH = ildec_pkg::RUN_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input items.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [0] line_level, [7:1] zero
  // Result items.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [15:0]                      out_tdata,  // [2:0] call_state, [3] lamp_on,
                                                       // [15:4] flat_number
  output logic                             out_tuser,  // [0] number_valid
  // Configuration writes.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ildec_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ildec_pkg::THR_W-1:0]      cfg_data
);
  import ildec_pkg::*;

  `include "assert_macros.svh"

  // Threshold registers.
  ildec_cfg_t thr;

  ildec_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .thr_o     (thr)
  );

  // Input register: one sampled level waiting for the state update.
  logic s1_valid_r;
  logic s1_level_r;
  logic s1_fire;

  // Call state held between items.
  ildec_ctrl_t          ctrl_r;
  ildec_ctrl_t          ctrl_nxt;
  logic [RUN_WIDTH-1:0] low_run_r;
  logic [RUN_WIDTH-1:0] low_run_nxt;
  logic [RUN_WIDTH-1:0] high_run_r;
  logic [RUN_WIDTH-1:0] high_run_nxt;
  logic                 number_valid_nxt;

  // Output register.
  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic        out_user_r;

  // The state update runs when an item is in the input register and the
  // output register is free or being emptied in this cycle.
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  ildec_step #(
    .RUN_WIDTH (RUN_WIDTH)
  ) u_step (
    .level_i        (s1_level_r),
    .thr_i          (thr),
    .ctrl_i         (ctrl_r),
    .low_run_i      (low_run_r),
    .high_run_i     (high_run_r),
    .ctrl_o         (ctrl_nxt),
    .low_run_o      (low_run_nxt),
    .high_run_o     (high_run_nxt),
    .number_valid_o (number_valid_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_level_r <= in_tdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r     <= CTRL_RST;
      low_run_r  <= '0;
      high_run_r <= '0;
    end else if (s1_fire) begin
      ctrl_r     <= ctrl_nxt;
      low_run_r  <= low_run_nxt;
      high_run_r <= high_run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= {ctrl_nxt.shown, ctrl_nxt.lamp, ctrl_nxt.mode};
      out_user_r <= number_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // A completed number is reported only as the call enters data received,
  // or connected when the idle threshold is zero.
  `ASSERT_IMP(a_number_state, clk, rst_n, out_valid_r && out_user_r,
              (out_data_r[2:0] == MODE_RECEIVED) || (out_data_r[2:0] == MODE_CONNECTED))

  // The lamp is dark exactly while the line is not connected.
  `ASSERT_IMP(a_lamp_mode, clk, rst_n, 1'b1,
              ctrl_r.lamp == (ctrl_r.mode != MODE_NOT_CONNECTED))

  // A state update always leaves a result in the output register.
  `ASSERT_NXT(a_fire_out, clk, rst_n, s1_fire, out_valid_r)

  // Pulse counting never drops to zero inside a digit.
  `ASSERT_IMP(a_pulse_nonzero, clk, rst_n,
              (ctrl_r.mode == MODE_FIRST) || (ctrl_r.mode == MODE_SECOND),
              ctrl_r.pulse_count != '0)

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Intercom line number decoder core testbench
// Feeds sampled line levels through the stream input, predicts the call
// state, lamp, number flag and flat number for every item and compares each
// result item against that prediction, under changing thresholds and
// changing amounts of idling and back-pressure on both channels.
// ---------------------------------------------------------------------------
module tb;
  import ildec_pkg::*;

  localparam int RUN_W = RUN_WIDTH_DEF;
  // Register indexes past the last threshold; the block must ignore them.
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [THR_W-1:0]      THR_MAX      = 16'hFFFF;
  localparam logic [RUN_W-1:0]      RUN_SAT      = '1;
  localparam int HOLD_CYCLES   = 60;
  localparam int DIGIT_WEIGHT  = 10;
  localparam int HUNDRED_LO    = 100;
  localparam int HUNDRED_HI    = 110;
  localparam int REPORT_LINES  = 50;
  localparam int LIMIT_NS      = 1000000;

  typedef struct packed {
    logic [MODE_W-1:0] state;
    logic              lamp;
    logic              number_valid;
    logic [NUM_W-1:0]  number;
  } line_report_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [0] line_level, [7:1] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [2:0] call_state, [3] lamp_on, [15:4] flat_number
  logic        out_tuser;         // [0] number_valid
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [THR_W-1:0]      cfg_data = '0;

  // Shadow of the decoder: thresholds and call machine state.
  ildec_cfg_t          limits;
  logic [MODE_W-1:0]   cur_mode;
  logic [RUN_W-1:0]    low_run;
  logic [RUN_W-1:0]    high_run;
  logic                last_lvl;
  logic [PULSE_W-1:0]  pulses;
  logic [NUM_W-1:0]    number_acc;
  logic                lamp;
  logic [NUM_W-1:0]    shown;

  line_report_t line_reports[$];   // predicted result items, oldest first
  int mismatches     = 0;
  int items_sent     = 0;
  int send_idle_pct  = 0;
  int sink_stall_pct = 0;
  int hold_req       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  intercom_line_number_decoder_core #(.RUN_WIDTH(RUN_W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // ------------------------------------------------------------------------
  // Call machine prediction
  // ------------------------------------------------------------------------

  // Any change of call state restarts the run counters and the pulse count.
  function automatic void enter_mode(input logic [MODE_W-1:0] m);
    cur_mode = m;
    if (m == MODE_NOT_CONNECTED) lamp = 1'b0;
    if (m == MODE_CONNECTED) lamp = 1'b1;
    low_run  = '0;
    high_run = '0;
    last_lvl = 1'b0;
    pulses   = PULSE_ONE;
  endfunction

  function automatic logic [RUN_W-1:0] run_step(input logic [RUN_W-1:0] v);
    return (v == RUN_SAT) ? v : v + 1'b1;
  endfunction

  function automatic line_report_t decode_level(input logic lvl);
    line_report_t r;
    logic [NUM_W-1:0]   n;
    logic [PULSE_W-1:0] p;
    r.number_valid = 1'b0;
    case (cur_mode)
      MODE_NOT_CONNECTED: begin
        if (lvl) enter_mode(MODE_CONNECTED);
      end
      MODE_CONNECTED: begin
        // A high leaves low_run alone, so a later high may still start a call.
        if (!lvl) begin
          low_run = run_step(low_run);
          if (low_run >= limits.disconnect) enter_mode(MODE_NOT_CONNECTED);
        end else if (low_run >= limits.call_start) begin
          enter_mode(MODE_FIRST);
        end
      end
      MODE_FIRST, MODE_SECOND: begin
        // Each falling edge is one dial pulse; the count stops at its maximum.
        if (lvl != last_lvl && last_lvl && pulses != PULSE_MAX) pulses = pulses + 1'b1;
        last_lvl = lvl;
        if (!lvl) begin
          high_run = '0;
          low_run  = run_step(low_run);
        end else begin
          low_run  = '0;
          high_run = run_step(high_run);
          if (high_run >= limits.digit_end) begin
            if (cur_mode == MODE_FIRST) begin
              number_acc = NUM_W'(pulses) * NUM_W'(DIGIT_WEIGHT);
              enter_mode(MODE_SECOND);
            end else begin
              // Eleven pulses stand for one; 101 to 109 drop the hundred.
              p = (pulses == PULSE_ELEVEN) ? PULSE_ONE : pulses;
              n = number_acc + NUM_W'(p) - 1'b1;
              if (n > HUNDRED_LO && n < HUNDRED_HI) n = n - NUM_W'(HUNDRED_LO);
              number_acc     = n;
              shown          = n;
              r.number_valid = 1'b1;
              enter_mode(MODE_RECEIVED);
            end
          end
          // Checked after a digit end too, when high_run has just been cleared.
          if (high_run >= limits.idle_high) enter_mode(MODE_CONNECTED);
        end
      end
      MODE_RECEIVED, MODE_ENDED: begin
        // Neither run clears the other in these two states.
        if (!lvl) begin
          low_run = run_step(low_run);
          if (cur_mode == MODE_RECEIVED) begin
            if (low_run >= limits.call_end) enter_mode(MODE_ENDED);
          end else if (low_run >= limits.disconnect) begin
            enter_mode(MODE_NOT_CONNECTED);
          end
        end else begin
          high_run = run_step(high_run);
          if (high_run >= limits.idle_high) enter_mode(MODE_CONNECTED);
        end
      end
      default: begin
        enter_mode(MODE_CONNECTED);
      end
    endcase
    r.state  = cur_mode;
    r.lamp   = lamp;
    r.number = shown;
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= REPORT_LINES)
      $display("%0t ns  mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Predictions are made when an item is taken and compared when a result item
  // leaves; both are sampled at the rising edge.
  always @(posedge clk) begin : check_results
    line_report_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) line_reports.push_back(decode_level(in_tdata[0]));
      if (out_tvalid && out_tready) begin
        if (line_reports.size() == 0) begin
          flag_mismatch("result item with none pending", out_tdata, 0);
        end else begin
          want = line_reports.pop_front();
          if (out_tdata[2:0] != want.state)
            flag_mismatch("call_state", out_tdata[2:0], want.state);
          if (out_tdata[3] != want.lamp)
            flag_mismatch("lamp_on", out_tdata[3], want.lamp);
          if (out_tuser != want.number_valid)
            flag_mismatch("number_valid", out_tuser, want.number_valid);
          if (out_tdata[15:4] != want.number)
            flag_mismatch("flat_number", out_tdata[15:4], want.number);
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready = 1'b0;
    end else begin
      out_tready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers; every task starts and ends at a falling edge.
  // ------------------------------------------------------------------------

  task automatic send_level(input logic lvl);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {7'd0, lvl};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_run(input logic lvl, input int count);
    repeat (count) send_level(lvl);
  endtask

  task automatic send_noise(input int runs);
    repeat (runs) send_run(1'($urandom_range(1)), $urandom_range(1, 6));
  endtask

  // Stop offering items and wait until every predicted result has come out.
  task automatic drain_results();
    in_tvalid = 1'b0;
    @(negedge clk);
    while (line_reports.size() != 0) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [CFG_ADDR_W-1:0] idx,
                                 input logic [THR_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_addr  = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DISCONNECT: limits.disconnect = val;
      REG_CALL_START: limits.call_start = val;
      REG_DIGIT_END:  limits.digit_end  = val;
      REG_IDLE_HIGH:  limits.idle_high  = val;
      REG_CALL_END:   limits.call_end   = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Thresholds are only rewritten once the block has nothing in flight.
  task automatic set_thresholds(input int dc, input int cs, input int de,
                                input int ih, input int ce);
    drain_results();
    write_threshold(REG_DISCONNECT, THR_W'(dc));
    write_threshold(REG_CALL_START, THR_W'(cs));
    write_threshold(REG_DIGIT_END,  THR_W'(de));
    write_threshold(REG_IDLE_HIGH,  THR_W'(ih));
    write_threshold(REG_CALL_END,   THR_W'(ce));
    cfg_valid = 1'b0;
  endtask

  task automatic bring_to_connected();
    int guard;
    guard = 0;
    while (cur_mode != MODE_CONNECTED && guard < 400) begin
      send_level(1'b1);
      guard++;
    end
  endtask

  // One dialled digit: short highs separated by lows, then a long high.
  // Long trains use single-tick pulses to keep the run short.
  task automatic send_digit(input int falls);
    int lim;
    lim = ((limits.digit_end < limits.idle_high) ? int'(limits.digit_end)
                                                 : int'(limits.idle_high)) - 1;
    if (lim > 4) lim = 4;
    repeat (falls) begin
      if (falls > 20 || lim < 1) begin
        send_level(1'b1);
        send_level(1'b0);
      end else begin
        send_run(1'b1, $urandom_range(1, lim));
        send_run(1'b0, $urandom_range(1, 3));
      end
    end
    send_run(1'b1, limits.digit_end);
  endtask

  // A complete call from the connected state. The ending either idles high
  // back to connected, walks down through call ended and not connected, or
  // trails off in noise.
  task automatic send_call(input int falls_a, input int falls_b, input int ending);
    int cs, dc, lows;
    bring_to_connected();
    cs   = limits.call_start;
    dc   = limits.disconnect;
    lows = cs;
    if (dc > cs + 1) lows = $urandom_range(cs, (cs + 3 < dc) ? cs + 3 : dc - 1);
    send_run(1'b0, lows);
    send_level(1'b1);
    send_digit(falls_a);
    send_digit(falls_b);
    case (ending)
      0: send_run(1'b1, limits.idle_high);
      1: begin
        send_run(1'b0, limits.call_end);
        send_run(1'b0, limits.disconnect);
        send_level(1'b1);
      end
      default: send_noise($urandom_range(1, 3));
    endcase
  endtask

  function automatic int pick_falls();
    return ($urandom_range(59) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 11);
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Thresholds as they come out of reset: a call that ends with eleven pulses.
  task automatic test_reset_defaults();
    send_send_idle(0, 0);
    send_run(1'b1, 2);
    send_call(2, 10, 2);
  endtask

  task automatic send_send_idle(input int snd, input int stl);
    send_idle_pct  = snd;
    sink_stall_pct = stl;
  endtask

  // Largest and smallest thresholds, and the mix that makes a call run at
  // once on single ticks.
  task automatic test_threshold_extremes();
    set_thresholds(THR_MAX, THR_MAX, THR_MAX, THR_MAX, THR_MAX);
    send_run(1'b0, 20);
    send_level(1'b1);
    send_noise(4);
    set_thresholds(1, 1, 1, 1, 1);
    send_noise(6);
    set_thresholds(THR_MAX, 1, 1, 1, 1);
    send_noise(8);
    send_call(0, 0, 2);
  endtask

  // Writes to indexes past the last register leave every threshold alone.
  task automatic test_spare_index();
    set_thresholds(20, 2, 3, 7, 4);
    write_threshold(REG_SPARE_LO, 16'd1);
    write_threshold(REG_SPARE_HI, THR_MAX);
    cfg_valid = 1'b0;
    send_call(3, 5, 0);
  endtask

  // Number forms: the hundred rule at both ends, eleven pulses as one,
  // the smallest number and a saturated pulse count with a full tear-down.
  task automatic test_number_forms();
    send_send_idle(26, 26);
    set_thresholds(24, 2, 3, 7, 4);
    send_call(9, 0, 0);
    send_call(9, 1, 0);
    send_call(9, 9, 1);
    send_call(9, 10, 0);
    send_call(10, 10, 0);
    send_call(2, 10, 2);
    send_call(0, 0, 0);
    send_call(258, 1, 1);
  endtask

  // Idle high inside a digit, and an idle threshold equal to the digit end,
  // where the idle check sees the cleared run and does not fire.
  task automatic test_idle_in_digit();
    set_thresholds(20, 2, 6, 3, 4);
    send_call(1, 1, 2);
    set_thresholds(20, 2, 3, 3, 4);
    send_call(2, 3, 0);
    send_call(4, 1, 1);
  endtask

  // The result side holds off for a long stretch while items keep coming,
  // so the block fills and stops taking input.
  task automatic test_back_pressure();
    send_send_idle(0, 0);
    set_thresholds(30, 3, 4, 9, 5);
    hold_req++;
    send_call(3, 6, 1);
    hold_req++;
    send_noise(10);
  endtask

  // The sender waits for every result between parts of a call.
  task automatic test_drain_pause();
    send_send_idle(57, 57);
    bring_to_connected();
    send_run(1'b0, limits.call_start);
    drain_results();
    send_level(1'b1);
    send_digit(5);
    drain_results();
    send_digit(7);
    drain_results();
    send_run(1'b1, limits.idle_high);
  endtask

  // Mostly well-formed calls with random digits, thresholds and endings;
  // the rest are aborted calls and plain noise.
  task automatic run_traffic_phase(input int snd, input int stl, input int count);
    int stop, pick, de;
    de = $urandom_range(2, 6);
    set_thresholds($urandom_range(6, 40), $urandom_range(1, 5), de,
                   ($urandom_range(99) < 85) ? $urandom_range(de + 1, de + 8)
                                             : $urandom_range(1, de),
                   $urandom_range(1, 8));
    send_send_idle(snd, stl);
    stop = items_sent + count;
    while (items_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        send_call(pick_falls(), pick_falls(), $urandom_range(2));
      end else if (pick < 90) begin
        bring_to_connected();
        send_run(1'b0, limits.call_start);
        send_level(1'b1);
        send_noise($urandom_range(1, 6));
      end else begin
        send_noise($urandom_range(1, 8));
      end
    end
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(0, 0, 20);
    run_traffic_phase(57, 0, 20);
    run_traffic_phase(0, 57, 20);
    run_traffic_phase(26, 26, 20);
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------

  initial begin
    limits.disconnect = THR_DISCONNECT_RST;
    limits.call_start = THR_CALL_START_RST;
    limits.digit_end  = THR_DIGIT_END_RST;
    limits.idle_high  = THR_IDLE_HIGH_RST;
    limits.call_end   = THR_CALL_END_RST;
    number_acc = CTRL_RST.number_acc;
    shown      = CTRL_RST.shown;
    enter_mode(CTRL_RST.mode);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_threshold_extremes();
    test_spare_index();
    test_number_forms();
    test_idle_in_digit();
    test_back_pressure();
    test_drain_pause();
    test_random_traffic();

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && line_reports.size() == 0) begin
      $display("intercom_line_number_decoder_core verification clean");
    end else begin
      $display("intercom_line_number_decoder_core verification failed");
    end
    $finish;
  end

  // Guard against a hang anywhere in the run.
  initial begin
    #(LIMIT_NS);
    $display("intercom_line_number_decoder_core verification failed");
    $finish;
  end

endmodule

// ===== intercom_line_number_decoder_core.f =====
+incdir+hdl
hdl/ildec_pkg.sv
hdl/ildec_cfg.sv
hdl/ildec_step.sv
hdl/intercom_line_number_decoder_core.sv
bench/tb.sv
